// ===== rtl/pdls_pkg.sv =====
`default_nettype none

package pdls_pkg;

    // field widths
    localparam int SAMPLE_W   = 10;
    localparam int SPEED_W    = 8;
    localparam int GAIN_W     = 12;
    localparam int WORD_W     = 12;
    localparam int ERR_W      = SAMPLE_W + 1;      // right - left
    localparam int DERR_W     = ERR_W + 1;         // err - previous err
    localparam int SUM_W      = 21;                // saturating error sum
    localparam int PROD_P_W   = ERR_W + GAIN_W + 1;
    localparam int PROD_I_W   = SUM_W + GAIN_W + 1;
    localparam int PROD_D_W   = DERR_W + GAIN_W + 1;
    localparam int ACC_W      = PROD_I_W + 1;
    localparam int FRAC_W     = 8;                 // Q4.8 gains
    localparam int CORR_W     = ACC_W - FRAC_W;
    localparam int WHEEL_W    = CORR_W + 1;

    // stream and config bus widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    // constants
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] BRAKE_WORD  = 12'd4095;
    localparam logic [WORD_W-1:0] WORD_OFFSET = 12'd15;
    localparam logic [FRAC_W-1:0] ROUND_BIAS  = 8'd255;

    // register reset values
    localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 12'd77;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 12'd0;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 12'd0;
    localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 8'd80;
    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 8'd130;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_BASE_SPEED  = 3'd3,
        REG_SPEED_LIMIT = 3'd4
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== rtl/pid_differential_line_steering_unit.sv =====
`default_nettype none

// Each of the four stages holds a beat; an accepted beat passes through them in order.
// Throughput: one beat per cycle while m_axis_tready does not stall; bubbles collapse.
// Stages: error/sum update, the three gain multipliers, correction sum, clamp and PWM words.
// Reset (synchronous, active low) empties the pipeline, clears the error sum and the
// previous error, and loads the gain, base speed and speed limit registers with defaults;
// s_axis_tready and o_cfg_ready stay low while reset is asserted.
module pid_differential_line_steering_unit
    import pdls_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,

    // config write channel
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]    i_cfg_data,

    // input stream
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    // [9:0] left_sample, [19:10] right_sample, [23:20] zero
    input  wire  [IN_TDATA_W-1:0]    s_axis_tdata,

    // result stream
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    // [7:0] left_speed, [15:8] right_speed, [27:16] motor0_word_a,
    // [39:28] motor0_word_b, [51:40] motor1_word_a, [63:52] motor1_word_b
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata
);

    // config registers
    logic [GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic [SPEED_W-1:0] r_base_speed, r_speed_limit;

    // controller state
    logic signed [ERR_W-1:0] r_prev_err;
    logic signed [SUM_W-1:0] r_error_sum;

    // stage 1: error terms
    logic                     r_v1;
    logic signed [ERR_W-1:0]  r_err1;
    logic signed [SUM_W-1:0]  r_sum1;
    logic signed [DERR_W-1:0] r_derr1;

    // stage 2: products
    logic                       r_v2;
    logic signed [PROD_P_W-1:0] r_prod_p;
    logic signed [PROD_I_W-1:0] r_prod_i;
    logic signed [PROD_D_W-1:0] r_prod_d;

    // stage 3: correction
    logic                     r_v3;
    logic signed [CORR_W-1:0] r_corr;

    // stage 4: result
    logic                   r_v4;
    logic [SPEED_W-1:0]     r_left_speed, r_right_speed;
    logic [WORD_W-1:0]      r_m0a, r_m0b, r_m1a, r_m1b;

    // handshake: each stage loads when it is empty or its beat moves on
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_beat;

    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign s_axis_tready = rdy1 && i_rst_n;
    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = i_rst_n;

    // stage 1 logic: error, saturating sum, error delta
    logic [SAMPLE_W-1:0]      left_in, right_in;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [DERR_W-1:0] n_derr;

    always_comb begin
        left_in  = s_axis_tdata[SAMPLE_W-1:0];
        right_in = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        n_err    = $signed({1'b0, right_in}) - $signed({1'b0, left_in});
        sum_wide = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(n_err);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            n_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = sum_wide[SUM_W-1:0];
        end
        n_derr = DERR_W'(n_err) - DERR_W'(r_prev_err);
    end

    // stage 2 logic: three gain multipliers in parallel
    logic signed [PROD_P_W-1:0] n_prod_p;
    logic signed [PROD_I_W-1:0] n_prod_i;
    logic signed [PROD_D_W-1:0] n_prod_d;

    always_comb begin
        n_prod_p = PROD_P_W'(r_err1)  * $signed({1'b0, r_gain_p});
        n_prod_i = PROD_I_W'(r_sum1)  * $signed({1'b0, r_gain_i});
        n_prod_d = PROD_D_W'(r_derr1) * $signed({1'b0, r_gain_d});
    end

    // stage 3 logic: sum and divide by 256, truncating toward zero
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_biased;
    logic signed [CORR_W-1:0] n_corr;

    always_comb begin
        acc = ACC_W'(r_prod_p) + ACC_W'(r_prod_i) + ACC_W'(r_prod_d);
        acc_biased = acc[ACC_W-1] ? acc + ACC_W'(ROUND_BIAS) : acc;
        n_corr = acc_biased[ACC_W-1:FRAC_W];
    end

    // stage 4 logic: wheel speeds, clamp, PWM words
    logic signed [WHEEL_W-1:0] left_raw, right_raw;
    logic [SPEED_W-1:0] n_left_speed, n_right_speed;
    logic [WORD_W-1:0]  n_m0a, n_m0b, n_m1a, n_m1b;

    always_comb begin
        left_raw  = $signed({{(WHEEL_W-SPEED_W){1'b0}}, r_base_speed}) - WHEEL_W'(r_corr);
        right_raw = $signed({{(WHEEL_W-SPEED_W){1'b0}}, r_base_speed}) + WHEEL_W'(r_corr);

        if (left_raw[WHEEL_W-1]) begin
            n_left_speed = '0;
        end else if (left_raw > $signed({{(WHEEL_W-SPEED_W){1'b0}}, r_speed_limit})) begin
            n_left_speed = r_speed_limit;
        end else begin
            n_left_speed = left_raw[SPEED_W-1:0];
        end

        if (right_raw[WHEEL_W-1]) begin
            n_right_speed = '0;
        end else if (right_raw > $signed({{(WHEEL_W-SPEED_W){1'b0}}, r_speed_limit})) begin
            n_right_speed = r_speed_limit;
        end else begin
            n_right_speed = right_raw[SPEED_W-1:0];
        end

        // motor 0 reversed on right speed, brake at zero
        if (n_right_speed == '0) begin
            n_m0a = BRAKE_WORD;
            n_m0b = BRAKE_WORD;
        end else begin
            n_m0a = {n_right_speed, 4'b0000} - WORD_OFFSET;
            n_m0b = '0;
        end

        // motor 1 forward on left speed, brake at zero
        if (n_left_speed == '0) begin
            n_m1a = BRAKE_WORD;
            n_m1b = BRAKE_WORD;
        end else begin
            n_m1a = '0;
            n_m1b = {n_left_speed, 4'b0000} + WORD_OFFSET;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= GAIN_P_RST;
            r_gain_i      <= GAIN_I_RST;
            r_gain_d      <= GAIN_D_RST;
            r_base_speed  <= BASE_SPEED_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GAIN_P:      r_gain_p      <= i_cfg_data;
                REG_GAIN_I:      r_gain_i      <= i_cfg_data;
                REG_GAIN_D:      r_gain_d      <= i_cfg_data;
                REG_BASE_SPEED:  r_base_speed  <= i_cfg_data[SPEED_W-1:0];
                REG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // controller state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err  <= '0;
            r_error_sum <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (in_beat) begin
                r_prev_err  <= n_err;
                r_error_sum <= n_sum;
            end
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_err1  <= n_err;
            r_sum1  <= n_sum;
            r_derr1 <= n_derr;
        end
        if (rdy2 && r_v1) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
        if (rdy3 && r_v2) begin
            r_corr <= n_corr;
        end
        if (rdy4 && r_v3) begin
            r_left_speed  <= n_left_speed;
            r_right_speed <= n_right_speed;
            r_m0a <= n_m0a;
            r_m0b <= n_m0b;
            r_m1a <= n_m1a;
            r_m1b <= n_m1b;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {r_m1b, r_m1a, r_m0b, r_m0a, r_right_speed, r_left_speed};

endmodule

`default_nettype wire

// ===== sim/pid_differential_line_steering_unit_tb.sv =====
`default_nettype none

module pid_differential_line_steering_unit_tb;
    import pdls_pkg::*;

    // indexes past the last register: writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    // result beat, left_speed in the lowest bits
    typedef struct packed {
        logic [WORD_W-1:0]  m1_word_b;
        logic [WORD_W-1:0]  m1_word_a;
        logic [WORD_W-1:0]  m0_word_b;
        logic [WORD_W-1:0]  m0_word_a;
        logic [SPEED_W-1:0] right_speed;
        logic [SPEED_W-1:0] left_speed;
    } t_steer;

    // one row of the directed table: a register write or a sample beat
    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [SAMPLE_W-1:0]   left;
        logic [SAMPLE_W-1:0]   right;
        bit                    lit;
        t_steer                want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    pid_differential_line_steering_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // controller state as the testbench tracks it
    logic [GAIN_W-1:0]       gain_p = GAIN_P_RST;
    logic [GAIN_W-1:0]       gain_i = GAIN_I_RST;
    logic [GAIN_W-1:0]       gain_d = GAIN_D_RST;
    logic [SPEED_W-1:0]      base_spd = BASE_SPEED_RST;
    logic [SPEED_W-1:0]      spd_limit = SPEED_LIMIT_RST;
    logic signed [ERR_W-1:0] prev_err = '0;
    logic signed [SUM_W-1:0] err_sum = '0;

    t_steer   pending_steer_q[$];
    t_dir_row dir_tbl[$];
    int       mismatch_count = 0;
    int       snd_idle_pct = 0;
    int       rcv_stall_pct = 0;
    bit       hold_req = 1'b0;
    bit       hold_done = 1'b0;
    int       hold_left = 0;

    function automatic t_steer mk_steer(input int ls, input int rs, input int m0a,
                                        input int m0b, input int m1a, input int m1b);
        t_steer s;
        s.left_speed  = ls[SPEED_W-1:0];
        s.right_speed = rs[SPEED_W-1:0];
        s.m0_word_a   = m0a[WORD_W-1:0];
        s.m0_word_b   = m0b[WORD_W-1:0];
        s.m1_word_a   = m1a[WORD_W-1:0];
        s.m1_word_b   = m1b[WORD_W-1:0];
        return s;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        t_dir_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val[CFG_DATA_W-1:0];
        return r;
    endfunction

    function automatic t_dir_row item_row(input int left, input int right);
        t_dir_row r;
        r = '0;
        r.left = left[SAMPLE_W-1:0];
        r.right = right[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic t_dir_row lit_row(input int left, input int right, input t_steer want);
        t_dir_row r;
        r = item_row(left, right);
        r.lit = 1'b1;
        r.want = want;
        return r;
    endfunction

    // PID step: saturating error sum, Q4.8 correction truncated toward zero,
    // per-wheel clamp, then H-bridge words (zero speed brakes)
    function automatic t_steer predict_steering(input logic [SAMPLE_W-1:0] left,
                                                input logic [SAMPLE_W-1:0] right);
        longint err, sum, acc, corr, ls, rs;
        t_steer res;
        err = longint'(right) - longint'(left);
        sum = longint'(err_sum) + err;
        if (sum > longint'(SUM_MAX)) sum = longint'(SUM_MAX);
        if (sum < longint'(SUM_MIN)) sum = longint'(SUM_MIN);
        acc = err * longint'(gain_p) + sum * longint'(gain_i)
            + (err - longint'(prev_err)) * longint'(gain_d);
        corr = acc / 256;
        ls = longint'(base_spd) - corr;
        rs = longint'(base_spd) + corr;
        if (ls > longint'(spd_limit)) ls = longint'(spd_limit);
        if (ls < 0) ls = 0;
        if (rs > longint'(spd_limit)) rs = longint'(spd_limit);
        if (rs < 0) rs = 0;
        err_sum = sum[SUM_W-1:0];
        prev_err = err[ERR_W-1:0];

        res.left_speed  = ls[SPEED_W-1:0];
        res.right_speed = rs[SPEED_W-1:0];
        if (rs == 0) begin
            res.m0_word_a = BRAKE_WORD;
            res.m0_word_b = BRAKE_WORD;
        end else begin
            res.m0_word_a = WORD_W'(16 * rs - 15);
            res.m0_word_b = '0;
        end
        if (ls == 0) begin
            res.m1_word_a = BRAKE_WORD;
            res.m1_word_b = BRAKE_WORD;
        end else begin
            res.m1_word_a = '0;
            res.m1_word_b = WORD_W'(16 * ls + 15);
        end
        return res;
    endfunction

    // mostly small steering errors, some full-range pairs and rail values
    function automatic logic [2*SAMPLE_W-1:0] random_pair();
        int l, r, pick;
        pick = $urandom_range(9);
        l = $urandom_range(1023);
        if (pick < 5) begin
            r = l + int'($urandom_range(80)) - 40;
            if (r < 0) r = 0;
            if (r > 1023) r = 1023;
        end else if (pick < 9) begin
            r = $urandom_range(1023);
        end else begin
            l = $urandom_range(1) * 1023;
            r = $urandom_range(1) * 1023;
        end
        return {r[SAMPLE_W-1:0], l[SAMPLE_W-1:0]};
    endfunction

    // sample beat; the expectation is queued at the accepting edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right,
                               input bit lit, input t_steer want);
        t_steer pred;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 2*SAMPLE_W){1'b0}}, right, left};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_steering(left, right);
        pending_steer_q.push_back(lit ? want : pred);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_steer_q.size() != 0) @(posedge i_clk);
    endtask

    // register write; valid stays up when another write follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last) i_cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN_P:      gain_p = val;
            REG_GAIN_I:      gain_i = val;
            REG_GAIN_D:      gain_d = val;
            REG_BASE_SPEED:  base_spd = val[SPEED_W-1:0];
            REG_SPEED_LIMIT: spd_limit = val[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_steering(input int gp, input int gi, input int gd,
                                    input int bs, input int lim);
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST));
        wait_for_results();
        write_reg(REG_GAIN_P, gp[CFG_DATA_W-1:0], 1'b0);
        write_reg(REG_GAIN_I, gi[CFG_DATA_W-1:0], 1'b0);
        write_reg(REG_GAIN_D, gd[CFG_DATA_W-1:0], 1'b0);
        write_reg(REG_BASE_SPEED, bs[CFG_DATA_W-1:0], 1'b0);
        write_reg(REG_SPEED_LIMIT, lim[CFG_DATA_W-1:0], 1'b0);
        write_reg(spare, CFG_DATA_W'($urandom), 1'b1);
    endtask

    task automatic set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_stall_pct <= rcv_pct;
    endtask

    task automatic report_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
        end
    endtask

    // result side: check accepted beats, then decide the next tready
    always @(posedge i_clk) begin : result_monitor
        t_steer got;
        t_steer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_steer_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, got);
            end else begin
                want = pending_steer_q.pop_front();
                report_field("left_speed", want.left_speed, got.left_speed);
                report_field("right_speed", want.right_speed, got.right_speed);
                report_field("motor0_word_a", want.m0_word_a, got.m0_word_a);
                report_field("motor0_word_b", want.m0_word_b, got.m0_word_b);
                report_field("motor1_word_a", want.m1_word_a, got.m1_word_a);
                report_field("motor1_word_b", want.m1_word_b, got.m1_word_b);
            end
        end

        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            // long back-pressure stretch so the pipeline fills
            hold_done = 1'b1;
            hold_left = 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // stimulus
    initial begin
        int ph, n, hits, gp, gi, gd, bs, lim;
        bit last;
        logic [2*SAMPLE_W-1:0] pair;

        // reset defaults: P gain only, base 80, limit 130
        dir_tbl.push_back(lit_row(0, 0, mk_steer(80, 80, 1265, 0, 0, 1295)));
        dir_tbl.push_back(lit_row(1023, 0, mk_steer(130, 0, 4095, 4095, 0, 2095)));
        dir_tbl.push_back(lit_row(0, 1023, mk_steer(0, 130, 2065, 0, 4095, 4095)));
        dir_tbl.push_back(lit_row(1023, 1023, mk_steer(80, 80, 1265, 0, 0, 1295)));
        // tiny errors truncate toward zero
        dir_tbl.push_back(lit_row(512, 511, mk_steer(80, 80, 1265, 0, 0, 1295)));
        dir_tbl.push_back(lit_row(511, 512, mk_steer(80, 80, 1265, 0, 0, 1295)));
        dir_tbl.push_back(lit_row(4, 0, mk_steer(81, 79, 1249, 0, 0, 1311)));
        // zero limit forces both wheels to brake
        dir_tbl.push_back(cfg_row(REG_SPEED_LIMIT, 0));
        dir_tbl.push_back(lit_row(300, 700, mk_steer(0, 0, 4095, 4095, 4095, 4095)));
        // full speed gives the top PWM words
        dir_tbl.push_back(cfg_row(REG_SPEED_LIMIT, 255));
        dir_tbl.push_back(cfg_row(REG_BASE_SPEED, 255));
        dir_tbl.push_back(cfg_row(REG_GAIN_P, 0));
        dir_tbl.push_back(lit_row(0, 1023, mk_steer(255, 255, 4065, 0, 0, 4095)));
        // all gains at maximum, derivative swings across the full range
        dir_tbl.push_back(cfg_row(REG_GAIN_P, 4095));
        dir_tbl.push_back(cfg_row(REG_GAIN_I, 4095));
        dir_tbl.push_back(cfg_row(REG_GAIN_D, 4095));
        dir_tbl.push_back(item_row(0, 1023));
        dir_tbl.push_back(item_row(1023, 0));
        dir_tbl.push_back(item_row(1023, 0));
        dir_tbl.push_back(item_row(0, 0));
        dir_tbl.push_back(item_row(1023, 1023));
        // ignored index, then unit gain from zero base speed
        dir_tbl.push_back(cfg_row(REG_SPARE_LAST, 4095));
        dir_tbl.push_back(cfg_row(REG_BASE_SPEED, 0));
        dir_tbl.push_back(cfg_row(REG_GAIN_P, 256));
        dir_tbl.push_back(cfg_row(REG_GAIN_I, 0));
        dir_tbl.push_back(cfg_row(REG_GAIN_D, 0));
        dir_tbl.push_back(lit_row(5, 5, mk_steer(0, 0, 4095, 4095, 4095, 4095)));
        dir_tbl.push_back(lit_row(0, 1, mk_steer(0, 1, 1, 0, 4095, 4095)));
        dir_tbl.push_back(lit_row(1, 0, mk_steer(1, 0, 4095, 4095, 0, 31)));
        // derivative only
        dir_tbl.push_back(cfg_row(REG_BASE_SPEED, 128));
        dir_tbl.push_back(cfg_row(REG_GAIN_P, 0));
        dir_tbl.push_back(cfg_row(REG_GAIN_D, 256));
        dir_tbl.push_back(item_row(0, 100));
        dir_tbl.push_back(item_row(0, 100));
        dir_tbl.push_back(item_row(100, 0));
        // integral only: the sum includes the current error
        dir_tbl.push_back(cfg_row(REG_GAIN_D, 0));
        dir_tbl.push_back(cfg_row(REG_GAIN_I, 256));
        dir_tbl.push_back(item_row(0, 10));
        dir_tbl.push_back(item_row(0, 10));
        dir_tbl.push_back(item_row(20, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < dir_tbl.size(); r++) begin
            if (dir_tbl[r].is_cfg) begin
                if (r == 0 || !dir_tbl[r-1].is_cfg) wait_for_results();
                last = (r == dir_tbl.size() - 1) || !dir_tbl[r+1].is_cfg;
                write_reg(dir_tbl[r].idx, dir_tbl[r].val, last);
            end else begin
                send_sample(dir_tbl[r].left, dir_tbl[r].right, dir_tbl[r].lit, dir_tbl[r].want);
            end
        end

        // random phases, each with its own settings and one of four idling patterns
        for (ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                gp = 4095; gi = 4095; gd = 4095; bs = 255; lim = 255;
            end else if (ph == 1) begin
                gp = 0; gi = 0; gd = 0; bs = 0; lim = 0;
            end else begin
                gp = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(600);
                gi = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(8);
                gd = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(400);
                bs = $urandom_range(255);
                lim = $urandom_range(255);
            end
            program_steering(gp, gi, gd, bs, lim);
            case (ph % 4)
                0: set_idling(0, 0);
                1: set_idling(52, 0);
                2: set_idling(0, 52);
                default: set_idling(16, 16);
            endcase
            if (ph == 4) hold_req <= 1'b1;
            for (n = 0; n < 12; n++) begin
                // one pause until everything has drained
                if (ph == 5 && n == 6) wait_for_results();
                pair = random_pair();
                send_sample(pair[SAMPLE_W-1:0], pair[2*SAMPLE_W-1:SAMPLE_W], 1'b0, '0);
            end
        end

        // integral windup: drive the sum into its upper limit, then back off it
        program_steering(0, 1, 0, 128, 255);
        set_idling(16, 16);
        hits = 0;
        while (hits < 8) begin
            send_sample(SAMPLE_W'($urandom_range(3)), SAMPLE_W'(1020 + $urandom_range(3)),
                        1'b0, '0);
            if (err_sum == SUM_MAX) hits++;
        end
        for (n = 0; n < 12; n++)
            send_sample(SAMPLE_W'(1020 + $urandom_range(3)), SAMPLE_W'($urandom_range(3)),
                        1'b0, '0);

        wait_for_results();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** pid_differential_line_steering_unit: PASSED **");
        end else begin
            $display("** pid_differential_line_steering_unit: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("** pid_differential_line_steering_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/pdls_pkg.sv
rtl/pid_differential_line_steering_unit.sv
sim/pid_differential_line_steering_unit_tb.sv
